/* design/assert_macros.svh */
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define HDE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent checked on the edge after the antecedent
`define HDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/hde_pkg.sv */
// types, constants and entity tables for the html entity decoder
package hde_pkg;

   localparam int HDE_QUEUE_DEPTH = 4;
   localparam int ENT_COUNT = 8;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] NUM_SAT = 8'd128;
   localparam logic [7:0] NUM_MAX = 8'd127;
   localparam logic [7:0] REPL_RESET = 8'h3F;
   localparam logic [7:0] ALL_NAMES = 8'hFF;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'b001,
      MODE_NAMED   = 3'b010,
      MODE_NUMERIC = 3'b100
   } mode_type;

   // output work for one accepted byte: held text flush, then up to two literals
   typedef struct packed {
      logic       flush_en;
      logic [2:0] flush_ent;
      logic [2:0] flush_len;
      logic [1:0] lit_count;
      logic [7:0] lit0;
      logic [7:0] lit1;
      logic       last;
   } hde_desc_type;

   // nbsp amp lt gt quot copy raquo laquo, without the leading ampersand
   localparam logic [7:0] ENT_TEXT [ENT_COUNT][8] = '{
      '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h63, 8'h6F, 8'h70, 8'h79, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h61, 8'h71, 8'h75, 8'h6F, 8'h3B, 8'h00, 8'h00},
      '{8'h6C, 8'h61, 8'h71, 8'h75, 8'h6F, 8'h3B, 8'h00, 8'h00}
   };
   localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{
      3'd5, 3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd6, 3'd6
   };
   localparam logic ENT_WIDE [ENT_COUNT] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
   };
   localparam logic [7:0] ENT_B0 [ENT_COUNT] = '{
      8'h20, 8'h26, 8'h3C, 8'h3E, 8'h22, 8'hC2, 8'hC2, 8'hC2
   };
   localparam logic [7:0] ENT_B1 [ENT_COUNT] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA9, 8'hBB, 8'hAB
   };

   // lowest set candidate
   function automatic logic [2:0] first_set(input logic [ENT_COUNT-1:0] set);
      logic [2:0] idx;
      idx = '0;
      for (int k = ENT_COUNT - 1; k >= 0; k--) begin
         if (set[k]) begin
            idx = 3'(k);
         end
      end
      return idx;
   endfunction

endpackage

/* design/html_entity_decoder.sv */
// top level of the streaming html entity decoder
//
//   channel   ports                                  handshake
//   request   req_in_byte, req_last                  push / full
//   response  rsp_out_byte, rsp_run_end,             empty / pop
//             rsp_string_end
//   csr       csr_data (replacement byte)            csr_valid / csr_ready
//
// a request byte is taken every cycle while the descriptor queue has room;
// the back end sends one decoded byte per cycle while the receiver keeps popping,
// so a byte that flushes held text (up to six bytes) holds the response side while
// those bytes go out, and the input stalls once the queue (QUEUE_DEPTH entries) fills.
// a decoded byte is registered in the queue and in the back end before it shows.
// synchronous reset returns to idle matching with replacement byte 0x3f.

module html_entity_decoder
   import hde_pkg::*;
#(
   parameter int QUEUE_DEPTH = HDE_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic         q_push, q_valid, q_pop;
   hde_desc_type push_desc, q_desc;

   assign csr_ready = 1'b1;

   hde_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_in_byte (req_in_byte),
      .req_last    (req_last),
      .csr_valid   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .q_push      (q_push),
      .q_desc      (push_desc)
   );

   hde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (full),
      .q_valid   (q_valid),
      .q_desc    (q_desc),
      .pop       (q_pop)
   );

   hde_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_desc         (q_desc),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

endmodule

/* design/hde_front.sv */
// front end: entity matching state and per-byte output descriptor
`include "assert_macros.svh"

module hde_front
   import hde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         full,
   input  logic [7:0]   req_in_byte,
   input  logic         req_last,
   input  logic         csr_valid,
   input  logic [7:0]   csr_data,
   output logic         q_push,
   output hde_desc_type q_desc
);

   mode_type      mode_ff, mode_in;
   logic [2:0]    prefix_ff, prefix_in;
   logic [7:0]    cand_ff, cand_in;
   logic [7:0]    value_ff, value_in;
   logic [7:0]    repl_ff;
   logic          accept;
   logic [7:0]    ns;
   logic          done_found;
   logic [2:0]    done_ent;
   logic          digit;
   logic [10:0]   acc;
   logic [7:0]    acc_sat;
   hde_desc_type  desc;

   assign accept = push && !full;

   function automatic logic [7:0] value_byte(input logic [7:0] v, input logic [7:0] repl);
      return (v != 8'd0 && v <= NUM_MAX) ? v : repl;
   endfunction

   always_comb begin
      ns = '0;
      for (int k = 0; k < ENT_COUNT; k++) begin
         if (cand_ff[k] && prefix_ff < ENT_LEN[k] && ENT_TEXT[k][prefix_ff] == req_in_byte) begin
            ns[k] = 1'b1;
         end
      end
   end

   always_comb begin
      done_found = 1'b0;
      done_ent = '0;
      for (int k = ENT_COUNT - 1; k >= 0; k--) begin
         if (ns[k] && ENT_LEN[k] == prefix_ff + 3'd1) begin
            done_found = 1'b1;
            done_ent = 3'(k);
         end
      end
   end

   assign digit = req_in_byte >= CH_ZERO && req_in_byte <= CH_NINE;
   assign acc = {3'b000, value_ff} * 11'd10 + {7'b0000000, req_in_byte[3:0]};
   assign acc_sat = (acc > {3'b000, NUM_SAT}) ? NUM_SAT : acc[7:0];

   always_comb begin
      mode_in = mode_ff;
      prefix_in = prefix_ff;
      cand_in = cand_ff;
      value_in = value_ff;
      desc = '0;
      desc.last = req_last;
      unique case (mode_ff)
         MODE_IDLE: begin
            prefix_in = '0;
            cand_in = ALL_NAMES;
            value_in = '0;
            if (req_in_byte == CH_AMP) begin
               mode_in = MODE_NAMED;
            end else begin
               desc.lit0 = req_in_byte;
               desc.lit_count = 2'd1;
            end
         end
         MODE_NAMED: begin
            if (prefix_ff == 3'd0 && req_in_byte == CH_HASH) begin
               mode_in = MODE_NUMERIC;
               value_in = '0;
            end else if (ns == 8'd0) begin
               desc.flush_en = 1'b1;
               desc.flush_ent = first_set(cand_ff);
               desc.flush_len = prefix_ff;
               prefix_in = '0;
               cand_in = ALL_NAMES;
               value_in = '0;
               if (req_in_byte == CH_AMP) begin
                  mode_in = MODE_NAMED;
               end else begin
                  mode_in = MODE_IDLE;
                  desc.lit0 = req_in_byte;
                  desc.lit_count = 2'd1;
               end
            end else if (done_found) begin
               desc.lit0 = ENT_B0[done_ent];
               desc.lit1 = ENT_B1[done_ent];
               desc.lit_count = ENT_WIDE[done_ent] ? 2'd2 : 2'd1;
               mode_in = MODE_IDLE;
               prefix_in = '0;
               cand_in = ALL_NAMES;
               value_in = '0;
            end else begin
               prefix_in = prefix_ff + 3'd1;
               cand_in = ns;
            end
         end
         MODE_NUMERIC: begin
            if (digit) begin
               value_in = acc_sat;
            end else begin
               desc.lit0 = value_byte(value_ff, repl_ff);
               desc.lit_count = 2'd1;
               mode_in = MODE_IDLE;
               prefix_in = '0;
               cand_in = ALL_NAMES;
               value_in = '0;
               if (req_in_byte == CH_AMP) begin
                  mode_in = MODE_NAMED;
               end else if (req_in_byte != CH_SEMI) begin
                  desc.lit1 = req_in_byte;
                  desc.lit_count = 2'd2;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            prefix_in = '0;
            cand_in = ALL_NAMES;
            value_in = '0;
         end
      endcase
      // end of string flushes whatever is pending
      if (req_last) begin
         if (mode_in == MODE_NAMED) begin
            if (prefix_in == 3'd0) begin
               if (desc.lit_count == 2'd0) begin
                  desc.lit0 = CH_AMP;
               end else begin
                  desc.lit1 = CH_AMP;
               end
               desc.lit_count = desc.lit_count + 2'd1;
            end else begin
               desc.flush_en = 1'b1;
               desc.flush_ent = first_set(cand_in);
               desc.flush_len = prefix_in;
            end
         end else if (mode_in == MODE_NUMERIC) begin
            desc.lit0 = value_byte(value_in, repl_ff);
            desc.lit_count = 2'd1;
         end
         mode_in = MODE_IDLE;
         prefix_in = '0;
         cand_in = ALL_NAMES;
         value_in = '0;
      end
   end

   assign q_push = accept && (desc.flush_en || desc.lit_count != 2'd0);
   assign q_desc = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         prefix_ff <= '0;
         cand_ff <= ALL_NAMES;
         value_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         prefix_ff <= prefix_in;
         cand_ff <= cand_in;
         value_ff <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_valid) begin
         repl_ff <= csr_data;
      end
   end

   `HDE_ASSERT_NEXT(last_returns_idle, clock, reset, accept && req_last, mode_ff == MODE_IDLE)
   `HDE_ASSERT(idle_state_clean, clock, reset,
      mode_ff == MODE_IDLE |-> prefix_ff == 3'd0 && cand_ff == ALL_NAMES && value_ff == 8'd0)

endmodule

/* design/hde_queue.sv */
// short descriptor queue between front and back
`include "assert_macros.svh"

module hde_queue
   import hde_pkg::*;
#(
   parameter int DEPTH = HDE_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hde_desc_type push_desc,
   output logic         full,
   output logic         q_valid,
   output hde_desc_type q_desc,
   input  logic         pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hde_desc_type     mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full = count_ff == CNT_FULL;
   assign q_valid = count_ff != '0;
   assign q_desc = mem[rd_ptr_ff];
   assign do_pop = pop && q_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `HDE_ASSERT(no_push_when_full, clock, reset, push |-> !full)
   `HDE_ASSERT(empty_ptrs_agree, clock, reset, count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)

endmodule

/* design/hde_back.sv */
// back end: expands descriptors into decoded bytes, one per cycle while the receiver keeps popping
`include "assert_macros.svh"

module hde_back
   import hde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  hde_desc_type q_desc,
   output logic         q_pop,
   output logic         empty,
   input  logic         pop,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_run_end,
   output logic         rsp_string_end
);

   logic [2:0] cnt_ff;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       run_end_ff, string_end_ff;
   logic [3:0] flush_count, total, cnt_wide, lit_idx;
   logic [2:0] text_idx;
   logic       fin, step;
   logic [7:0] cur_byte;

   assign flush_count = q_desc.flush_en ? {1'b0, q_desc.flush_len} + 4'd1 : 4'd0;
   assign total = flush_count + {2'b00, q_desc.lit_count};
   assign cnt_wide = {1'b0, cnt_ff};
   assign fin = cnt_wide == total - 4'd1;
   assign text_idx = cnt_ff - 3'd1;
   assign lit_idx = cnt_wide - flush_count;
   assign step = q_valid && (!rsp_valid_ff || pop);
   assign q_pop = step && fin;

   always_comb begin
      priority if (q_desc.flush_en && cnt_ff == 3'd0) begin
         cur_byte = CH_AMP;
      end else if (q_desc.flush_en && cnt_wide <= {1'b0, q_desc.flush_len}) begin
         cur_byte = ENT_TEXT[q_desc.flush_ent][text_idx];
      end else if (lit_idx == 4'd0) begin
         cur_byte = q_desc.lit0;
      end else begin
         cur_byte = q_desc.lit1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            cnt_ff <= fin ? 3'd0 : cnt_ff + 3'd1;
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff <= cur_byte;
         run_end_ff <= fin;
         string_end_ff <= fin && q_desc.last;
      end
   end

   assign empty = !rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end = run_end_ff;
   assign rsp_string_end = string_end_ff;

   `HDE_ASSERT(cnt_within_entry, clock, reset, q_valid |-> cnt_wide < total)
   `HDE_ASSERT_NEXT(step_fills_output, clock, reset, step, rsp_valid_ff)

endmodule

/* tb/tb_html_entity_decoder.sv */
// self-checking testbench for the streaming html entity decoder
`timescale 1ns / 100ps

module tb_html_entity_decoder
   import hde_pkg::*;
();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [7:0] NAME_TEXT [8][8] = '{
      '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h63, 8'h6F, 8'h70, 8'h79, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h61, 8'h71, 8'h75, 8'h6F, 8'h3B, 8'h00, 8'h00},
      '{8'h6C, 8'h61, 8'h71, 8'h75, 8'h6F, 8'h3B, 8'h00, 8'h00}
   };
   localparam int NAME_LEN [8] = '{5, 4, 3, 3, 5, 5, 6, 6};
   localparam logic NAME_WIDE [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
   localparam logic [7:0] NAME_B0 [8] = '{
      8'h20, 8'h26, 8'h3C, 8'h3E, 8'h22, 8'hC2, 8'hC2, 8'hC2
   };
   localparam logic [7:0] NAME_B1 [8] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA9, 8'hBB, 8'hAB
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } decoded_type;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_in_byte;
   logic       req_last;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_end;
   logic       rsp_string_end;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   // decoder state as predicted
   mode_type   dec_mode;
   logic [2:0] dec_prefix;
   logic [7:0] dec_cands;
   logic [7:0] dec_value;
   logic [7:0] repl_byte;

   decoded_type pending_bytes[$];
   logic [7:0]  step_bytes[$];
   logic [7:0]  text[$];

   int errors;
   int cycles;
   int sender_idle_pct;
   int receiver_idle_pct;

   html_entity_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_in_byte    (req_in_byte),
      .req_last       (req_last),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void go_idle();
      dec_mode   = MODE_IDLE;
      dec_prefix = '0;
      dec_cands  = ALL_NAMES;
      dec_value  = '0;
   endfunction

   function automatic void take_plain(input logic [7:0] c);
      if (c == CH_AMP) begin
         go_idle();
         dec_mode = MODE_NAMED;
      end else begin
         step_bytes.push_back(c);
      end
   endfunction

   function automatic void flush_held();
      bit found;
      found = 1'b0;
      step_bytes.push_back(CH_AMP);
      for (int k = 0; k < 8; k++) begin
         if (!found && dec_cands[k]) begin
            found = 1'b1;
            for (int i = 0; i < int'(dec_prefix); i++) begin
               step_bytes.push_back(NAME_TEXT[k][i]);
            end
         end
      end
   endfunction

   function automatic void numeric_byte();
      if (dec_value >= 8'd1 && dec_value <= NUM_MAX) begin
         step_bytes.push_back(dec_value);
      end else begin
         step_bytes.push_back(repl_byte);
      end
   endfunction

   // expected decoded bytes for one accepted text byte
   function automatic void decode_byte(input logic [7:0] c, input logic l);
      logic [7:0]  hits;
      int          done;
      int          p;
      int          v;
      decoded_type rec;
      step_bytes.delete();
      p = int'(dec_prefix);
      case (dec_mode)
         MODE_NAMED: begin
            if (p == 0 && c == CH_HASH) begin
               dec_mode  = MODE_NUMERIC;
               dec_value = '0;
            end else begin
               hits = '0;
               done = -1;
               for (int k = 0; k < 8; k++) begin
                  if (dec_cands[k] && p < NAME_LEN[k] && NAME_TEXT[k][p] == c) begin
                     hits[k] = 1'b1;
                  end
               end
               for (int k = 0; k < 8; k++) begin
                  if (done < 0 && hits[k] && NAME_LEN[k] == p + 1) begin
                     done = k;
                  end
               end
               if (hits == '0) begin
                  flush_held();
                  go_idle();
                  take_plain(c);
               end else if (done >= 0) begin
                  step_bytes.push_back(NAME_B0[done]);
                  if (NAME_WIDE[done]) begin
                     step_bytes.push_back(NAME_B1[done]);
                  end
                  go_idle();
               end else begin
                  dec_prefix = 3'(p + 1);
                  dec_cands  = hits;
               end
            end
         end
         MODE_NUMERIC: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
               v = int'(dec_value) * 10 + (int'(c) - int'(CH_ZERO));
               dec_value = (v > int'(NUM_SAT)) ? NUM_SAT : 8'(v);
            end else begin
               numeric_byte();
               go_idle();
               if (c != CH_SEMI) begin
                  take_plain(c);
               end
            end
         end
         default: begin
            go_idle();
            take_plain(c);
         end
      endcase
      if (l) begin
         if (dec_mode == MODE_NAMED) begin
            flush_held();
         end else if (dec_mode == MODE_NUMERIC) begin
            numeric_byte();
         end
         go_idle();
      end
      foreach (step_bytes[i]) begin
         rec.out_byte   = step_bytes[i];
         rec.run_end    = (i == step_bytes.size() - 1);
         rec.string_end = rec.run_end && l;
         pending_bytes.push_back(rec);
      end
   endfunction

   // entered and left at a falling edge; push stays high between back-to-back bytes
   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_in_byte <= b;
      req_last    <= l;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      decode_byte(b, l);
      @(negedge clock);
   endtask

   task automatic send_pending_text();
      for (int i = 0; i < text.size(); i++) begin
         send_byte(text[i], i == text.size() - 1);
      end
      text.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text.push_back(s[i]);
      end
      send_pending_text();
   endtask

   task automatic add_token();
      int pick;
      int k;
      int n;
      pick = $urandom_range(99);
      if (pick < 35) begin
         k = $urandom_range(7);
         text.push_back(CH_AMP);
         for (int t = 0; t < NAME_LEN[k]; t++) begin
            text.push_back(NAME_TEXT[k][t]);
         end
      end else if (pick < 55) begin
         text.push_back(CH_AMP);
         text.push_back(CH_HASH);
         n = $urandom_range(4);
         for (int t = 0; t < n; t++) begin
            text.push_back(CH_ZERO + 8'($urandom_range(9)));
         end
         if ($urandom_range(2) != 0) begin
            text.push_back(CH_SEMI);
         end
      end else if (pick < 70) begin
         // name cut short and broken by an arbitrary byte
         k = $urandom_range(7);
         n = $urandom_range(NAME_LEN[k] - 1);
         text.push_back(CH_AMP);
         for (int t = 0; t < n; t++) begin
            text.push_back(NAME_TEXT[k][t]);
         end
         text.push_back(8'($urandom_range(255)));
      end else begin
         text.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_numeric_forms();
      send_text("&#39;");
      send_text("&#;");
      send_text("&#999");
      send_text("&#65x");
   endtask

   task automatic test_broken_names();
      send_text("&am&");
      send_text("&laquo;");
      send_text("&quo");
   endtask

   task automatic test_random_text(input int count);
      int sent;
      int tokens;
      sent = 0;
      while (sent < count) begin
         tokens = $urandom_range(1, 8);
         for (int t = 0; t < tokens; t++) begin
            add_token();
         end
         sent += text.size();
         send_pending_text();
      end
   endtask

   task automatic test_replacement_write(input logic [7:0] v);
      push <= 1'b0;
      while (pending_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      repl_byte = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin : check_results
      decoded_type want;
      if (!reset && pop && !empty) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual out_byte %h",
                     $time, rsp_out_byte);
            errors++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h",
                        $time, want.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_run_end !== want.run_end) begin
               $display("%0t: run_end expected %b actual %b",
                        $time, want.run_end, rsp_run_end);
               errors++;
            end
            if (rsp_string_end !== want.string_end) begin
               $display("%0t: string_end expected %b actual %b",
                        $time, want.string_end, rsp_string_end);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      errors            = 0;
      cycles            = 0;
      sender_idle_pct   = 9;
      receiver_idle_pct = 82;
      reset       = 1'b1;
      push        = 1'b0;
      req_in_byte = '0;
      req_last    = 1'b0;
      pop         = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      repl_byte   = REPL_RESET;
      go_idle();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_byte_extremes();
      test_numeric_forms();
      test_broken_names();
      test_random_text(90);

      test_replacement_write(8'h00);
      sender_idle_pct   = 82;
      receiver_idle_pct = 9;
      test_numeric_forms();
      test_random_text(90);

      test_replacement_write(8'hFF);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_numeric_forms();
      test_random_text(90);

      test_replacement_write(8'($urandom_range(255)));
      test_numeric_forms();
      test_random_text(30);

      push <= 1'b0;
      while (pending_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
